### hw/rtl/fr_pkg.sv
// -----------------------------------------------------------------------------
// fr_pkg: shared types for the fraction reducer
// Sequencer state encoding for the top level.
// -----------------------------------------------------------------------------
package fr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_GCD     = 2'd1,
      ST_DIV_NUM = 2'd2,
      ST_DIV_DEN = 2'd3
   } fr_state_type;

endpackage

### hw/rtl/fr_gcd.sv
// -----------------------------------------------------------------------------
// fr_gcd: iterative binary gcd
// One shift or one compare-and-subtract per cycle, common factors of two
// counted and restored at the end. b must be non-zero.
// -----------------------------------------------------------------------------
module fr_gcd #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] g
);
   import fr_pkg::*;

   localparam int KW = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         k_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (a_ff == '0) begin
            g_in    = b_ff << k_ff;
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

### hw/rtl/fr_div.sv
// -----------------------------------------------------------------------------
// fr_div: serial restoring divider
// One quotient bit per cycle until all DATA_WIDTH quotient bits are formed.
// -----------------------------------------------------------------------------
module fr_div #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);
   import fr_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  run_ff, run_in, done_ff, done_in;
   logic [DATA_WIDTH:0]   trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CW'(DATA_WIDTH - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[DATA_WIDTH]) begin
            rem_in = diff[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/fraction_reduce.sv
// -----------------------------------------------------------------------------
// fraction_reduce: signed fraction to lowest terms
// Sign folding, binary gcd, then two serial divisions by the gcd.
// -----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown for a single cycle with rsp_valid high. The
// receiver cannot stall, so capture the result on that cycle.
// A zero denominator never raises busy. Its result, with rsp_zero_denominator
// set and 0/0, is shown in the cycle straight after the accepting edge.
// Any other request raises busy until its result is written. The binary gcd
// works through shift and subtract steps, then finishes with one more step. The
// shared divider then divides the numerator and then the denominator by the gcd.
// busy drops in the same cycle as rsp_valid is raised, so the next request may
// follow straight away.
// -----------------------------------------------------------------------------
module fraction_reduce #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_numerator,
   input  logic signed [DATA_WIDTH-1:0] req_denominator,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH:0]   rsp_reduced_numerator,
   output logic        [DATA_WIDTH-1:0] rsp_reduced_denominator,
   output logic                         rsp_zero_denominator
);
   import fr_pkg::*;

   fr_state_type state_ff, state_in;

   // magnitudes of the request; the most negative value maps to 2^(W-1)
   logic                  num_neg, den_neg;
   logic [DATA_WIDTH-1:0] num_mag, den_mag;

   logic [DATA_WIDTH-1:0] num_mag_ff, num_mag_in, den_mag_ff, den_mag_in;
   logic                  neg_ff, neg_in;
   logic [DATA_WIDTH-1:0] q_num_ff, q_num_in;

   logic                  accept;
   logic                  gcd_start, gcd_done;
   logic [DATA_WIDTH-1:0] gcd_value;
   logic                  div_start, div_done;
   logic [DATA_WIDTH-1:0] div_dividend, div_quotient;

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH:0]   rnum_ff, rnum_in;
   logic [DATA_WIDTH-1:0] rden_ff, rden_in;
   logic                  zden_ff, zden_in;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);

   assign num_neg = req_numerator[DATA_WIDTH-1];
   assign den_neg = req_denominator[DATA_WIDTH-1];
   assign num_mag = num_neg ? ({DATA_WIDTH{1'b0}} - $unsigned(req_numerator))
                            : $unsigned(req_numerator);
   assign den_mag = den_neg ? ({DATA_WIDTH{1'b0}} - $unsigned(req_denominator))
                            : $unsigned(req_denominator);

   // numerator goes through the divider first, then the denominator
   assign div_dividend = (state_ff == ST_GCD) ? num_mag_ff : den_mag_ff;

   always_comb begin
      state_in   = state_ff;
      num_mag_in = num_mag_ff;
      den_mag_in = den_mag_ff;
      neg_in     = neg_ff;
      q_num_in   = q_num_ff;
      gcd_start  = 1'b0;
      div_start  = 1'b0;
      valid_in   = 1'b0;
      rnum_in    = rnum_ff;
      rden_in    = rden_ff;
      zden_in    = zden_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               num_mag_in = num_mag;
               den_mag_in = den_mag;
               neg_in     = num_neg ^ den_neg;
               if (den_mag == '0) begin
                  // zero denominator: flag it and answer 0/0 at once
                  valid_in = 1'b1;
                  rnum_in  = '0;
                  rden_in  = '0;
                  zden_in  = 1'b1;
               end else begin
                  gcd_start = 1'b1;
                  state_in  = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (div_done) begin
               q_num_in  = div_quotient;
               div_start = 1'b1;
               state_in  = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (div_done) begin
               // a zero quotient negates to zero, so no special case
               valid_in = 1'b1;
               rnum_in  = neg_ff ? ((DATA_WIDTH+1)'(0) - {1'b0, q_num_ff})
                                 : {1'b0, q_num_ff};
               rden_in  = div_quotient;
               zden_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      num_mag_ff <= num_mag_in;
      den_mag_ff <= den_mag_in;
      neg_ff     <= neg_in;
      q_num_ff   <= q_num_in;
      rnum_ff    <= rnum_in;
      rden_ff    <= rden_in;
      zden_ff    <= zden_in;
   end

   fr_gcd #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .a     (num_mag),
      .b     (den_mag),
      .done  (gcd_done),
      .g     (gcd_value)
   );

   // gcd result is held in u_gcd until its next start, so it serves both divisions
   fr_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_value),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid               = valid_ff;
   assign rsp_reduced_numerator   = $signed(rnum_ff);
   assign rsp_reduced_denominator = rden_ff;
   assign rsp_zero_denominator    = zden_ff;

endmodule

### bench/fraction_reduce_tb.sv
// -----------------------------------------------------------------------------
// fraction_reduce_tb: self-checking bench for the fraction reducer
// Drives signed numerator/denominator requests (a directed table, then a
// random mix biased towards shared factors, trailing zeros and extremes),
// predicts or looks up each reduced fraction and checks every result field in order.
// -----------------------------------------------------------------------------
module fraction_reduce_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam int RANDOM_REQUESTS = 1250;
   localparam int QUIET_TAIL = 150;           // final requests sent back to back
   localparam int DRAIN_CYCLES = 400;         // > worst-case latency of one request
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam longint MIN_VAL = -(64'sd1 <<< (DW - 1));
   localparam longint MAX_VAL = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint TOP_MAG = 64'sd1 <<< (DW - 1);

   // one reduced fraction as it leaves the block
   typedef struct packed {
      logic signed [DW:0] num;
      logic [DW-1:0]      den;
      logic               zero_den;
   } fraction_type;

   // directed stimulus; the expected fraction is filled in only where obvious
   typedef struct packed {
      longint num;
      longint den;
      bit     typed;
      longint exp_num;
      longint exp_den;
      bit     exp_zero;
   } directed_row_type;

   localparam int N_DIRECTED = 23;
   directed_row_type directed_rows [N_DIRECTED] = '{
      // zero denominator: flagged, 0/0
      '{0,        0,        1, 0,        0,       1},
      '{5,        0,        1, 0,        0,       1},
      '{MIN_VAL,  0,        1, 0,        0,       1},
      '{MAX_VAL,  0,        1, 0,        0,       1},
      // zero numerator gives 0/1, even over the most negative denominator
      '{0,        7,        1, 0,        1,       0},
      '{0,        MIN_VAL,  1, 0,        1,       0},
      '{0,        -1,       1, 0,        1,       0},
      // most negative value kept exact
      '{MIN_VAL,  -1,       1, TOP_MAG,  1,       0},
      '{MIN_VAL,  1,        1, MIN_VAL,  1,       0},
      '{1,        MIN_VAL,  1, -1,       TOP_MAG, 0},
      '{-1,       MIN_VAL,  1, 1,        TOP_MAG, 0},
      '{MIN_VAL,  MIN_VAL,  1, 1,        1,       0},
      '{MAX_VAL,  MAX_VAL,  1, 1,        1,       0},
      '{MAX_VAL,  1,        1, MAX_VAL,  1,       0},
      '{MAX_VAL,  -1,       1, -MAX_VAL, 1,       0},
      '{MAX_VAL,  MIN_VAL,  1, -MAX_VAL, TOP_MAG, 0},
      '{MIN_VAL,  MAX_VAL,  1, MIN_VAL,  MAX_VAL, 0},
      // general cases, left to the predictor
      '{6,        -4,       0, 0, 0, 0},
      '{-12,      18,       0, 0, 0, 0},
      '{1000000,  250,      0, 0, 0, 0},
      '{-MAX_VAL, -3,       0, 0, 0, 0},
      '{64'sh40000000, 64'sh20000000, 0, 0, 0, 0},
      '{12345678, -87654321, 0, 0, 0, 0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic signed [DW-1:0] req_numerator = '0;
   logic signed [DW-1:0] req_denominator = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic signed [DW:0]   rsp_reduced_numerator;
   logic [DW-1:0]        rsp_reduced_denominator;
   logic                 rsp_zero_denominator;

   fraction_type expected_fractions [$];
   int        mismatches = 0;
   int        results_checked = 0;
   int        zero_den_results = 0;
   int        negative_results = 0;
   int        cycle_count = 0;

   fraction_reduce #(
      .DATA_WIDTH(DW)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_numerator(req_numerator),
      .req_denominator(req_denominator),
      .rsp_valid(rsp_valid),
      .rsp_reduced_numerator(rsp_reduced_numerator),
      .rsp_reduced_denominator(rsp_reduced_denominator),
      .rsp_zero_denominator(rsp_zero_denominator)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor: fold signs so the denominator is positive, then divide both
   // magnitudes by their gcd. 64-bit arithmetic keeps 2^(DW-1) exact.
   function automatic fraction_type reduce_fraction(logic signed [DW-1:0] num,
                                                    logic signed [DW-1:0] den);
      fraction_type   res;
      longint         s_num;
      longint         s_den;
      longint         signed_q;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      longint unsigned q_num;
      longint unsigned q_den;
      s_num = num;
      s_den = den;
      res = '0;
      if (s_den == 0) begin
         res.zero_den = 1'b1;
         return res;
      end
      a = (s_num < 0) ? -s_num : s_num;
      b = (s_den < 0) ? -s_den : s_den;
      q_num = a;
      q_den = b;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      q_num = q_num / a;
      q_den = q_den / a;
      signed_q = ((s_num < 0) != (s_den < 0)) ? -longint'(q_num) : longint'(q_num);
      res.num = signed_q[DW:0];
      res.den = q_den[DW-1:0];
      return res;
   endfunction

   // Random operands, biased so that gcd steps, shifts and sign folds all get
   // exercised rather than mostly coprime pairs.
   function automatic longint pick_extreme();
      case ($urandom_range(0, 5))
         0: return MIN_VAL;
         1: return MAX_VAL;
         2: return 0;
         3: return 1;
         4: return -1;
         default: return MIN_VAL + 1;
      endcase
   endfunction

   task automatic make_operands(output logic [DW-1:0] num, output logic [DW-1:0] den);
      longint factor;
      longint a;
      longint b;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            num = $urandom;
            den = $urandom;
         end
         3, 4, 5: begin
            // shared factor, random signs
            factor = $urandom_range(1, 5000);
            a = factor * $urandom_range(0, 40000);
            b = factor * $urandom_range(1, 40000);
            num = DW'(($urandom_range(0, 1) != 0) ? -a : a);
            den = DW'(($urandom_range(0, 1) != 0) ? -b : b);
         end
         6: begin
            a = longint'($urandom_range(0, 40)) - 20;
            b = longint'($urandom_range(0, 40)) - 20;
            num = DW'(a);
            den = DW'(b);
         end
         7: begin
            // heavy trailing zeros on both sides
            num = $urandom << $urandom_range(0, DW - 1);
            den = $urandom << $urandom_range(0, DW - 1);
         end
         8: begin
            num = ($urandom_range(0, 1) != 0) ? DW'(pick_extreme()) : $urandom;
            den = ($urandom_range(0, 1) != 0) ? DW'(pick_extreme()) : $urandom;
         end
         default: begin
            num = $urandom;
            case ($urandom_range(0, 3))
               0: den = 0;
               1: den = 1;
               2: den = -1;
               default: den = num * ($urandom_range(0, 1) != 0 ? -1 : 1);
            endcase
         end
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [DW-1:0] num, input logic [DW-1:0] den,
                               input bit typed, input fraction_type typed_fraction);
      req_numerator <= num;
      req_denominator <= den;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      expected_fractions.push_back(typed ? typed_fraction : reduce_fraction(num, den));
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   function automatic int pick_gap(bit quiet);
      if (quiet || $urandom_range(0, 3) != 0)
         return 0;
      return $urandom_range(1, 9);
   endfunction

   // result checking: the block cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      fraction_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_fractions.size());
         $display("[fraction_reduce] ERROR");
         $finish;
      end else if (!reset && rsp_valid === 1'b1) begin
         if (expected_fractions.size() == 0) begin
            $error("unexpected result %0d/%0d (zero_denominator %0b)",
                   rsp_reduced_numerator, rsp_reduced_denominator, rsp_zero_denominator);
            mismatches++;
         end else begin
            want = expected_fractions.pop_front();
            results_checked++;
            if (want.zero_den)
               zero_den_results++;
            if (want.num[DW])
               negative_results++;
            if (rsp_reduced_numerator !== want.num) begin
               $error("reduced_numerator: expected %0d, got %0d",
                      want.num, rsp_reduced_numerator);
               mismatches++;
            end
            if (rsp_reduced_denominator !== want.den) begin
               $error("reduced_denominator: expected %0d, got %0d",
                      want.den, rsp_reduced_denominator);
               mismatches++;
            end
            if (rsp_zero_denominator !== want.zero_den) begin
               $error("zero_denominator: expected %0b, got %0b",
                      want.zero_den, rsp_zero_denominator);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin
      fraction_type  typed_fraction;
      logic [DW-1:0] num;
      logic [DW-1:0] den;
      bit            quiet;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         typed_fraction.num = directed_rows[i].exp_num[DW:0];
         typed_fraction.den = directed_rows[i].exp_den[DW-1:0];
         typed_fraction.zero_den = directed_rows[i].exp_zero;
         send_request(directed_rows[i].num[DW-1:0], directed_rows[i].den[DW-1:0],
                      directed_rows[i].typed, typed_fraction);
         idle_for(pick_gap(1'b0));
      end

      // random part; idling switched on and off per stretch, none at the tail
      quiet = 1'b0;
      typed_fraction = '0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0)
            quiet = ($urandom_range(0, 2) == 0);
         if (n >= RANDOM_REQUESTS - QUIET_TAIL)
            quiet = 1'b1;
         make_operands(num, den);
         send_request(num, den, 1'b0, typed_fraction);
         idle_for(pick_gap(quiet));
      end
      start <= 1'b0;

      wait (expected_fractions.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d directed and %0d random requests; %0d results checked",
               N_DIRECTED, RANDOM_REQUESTS, results_checked);
      $display("%0d zero-denominator results, %0d with a negative numerator",
               zero_den_results, negative_results);
      if (mismatches == 0 && expected_fractions.size() == 0) begin
         $display("[fraction_reduce] OK");
      end else begin
         $display("[fraction_reduce] ERROR");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/fr_pkg.sv
hw/rtl/fr_gcd.sv
hw/rtl/fr_div.sv
hw/rtl/fraction_reduce.sv
bench/fraction_reduce_tb.sv
